FILE: rtl/slol_pkg.sv
package slol_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Fixed field widths
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 4;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Stream widths, padded to whole bytes
	localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOK   = 2'd2,
		FUNC_TAKE   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_ADD,
		S_WALK,
		S_READ,
		S_DONE
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;       // capture input beat, arm scan and walk
		logic scan_step;  // advance free-slot scan
		logic add_wr;     // write and link new entry at scan slot
		logic walk_step;  // follow one forward link
		logic read_ent;   // read payload and links of current slot
		logic unlink;     // unlink current slot and free it
		logic res_ok;     // result: ok, payload for look/take
		logic res_full;   // result: list full
		logic res_absent; // result: position not present
		logic out_load;   // move result into output register
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		func_t func;
		logic  full;
		logic  absent;
		logic  scan_hit;
		logic  steps_zero;
	} stat_t;

endpackage

FILE: rtl/slol_ctrl.sv
module slol_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  slol_pkg::stat_t stat,
	output slol_pkg::cmd_t  cmd
);

	slol_pkg::state_t state_q, state_nxt;
	logic             m_tvalid_q;
	logic             out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slol_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slol_pkg::S_IDLE: begin
				if (s_tvalid) state_nxt = slol_pkg::S_DECODE;
			end
			slol_pkg::S_DECODE: begin
				if (stat.func == slol_pkg::FUNC_ADD) begin
					state_nxt = stat.full ? slol_pkg::S_DONE : slol_pkg::S_SCAN;
				end else begin
					state_nxt = stat.absent ? slol_pkg::S_DONE : slol_pkg::S_WALK;
				end
			end
			slol_pkg::S_SCAN: begin
				if (stat.scan_hit) state_nxt = slol_pkg::S_ADD;
			end
			slol_pkg::S_ADD: begin
				state_nxt = slol_pkg::S_DONE;
			end
			slol_pkg::S_WALK: begin
				if (stat.steps_zero) state_nxt = slol_pkg::S_READ;
			end
			slol_pkg::S_READ: begin
				state_nxt = slol_pkg::S_DONE;
			end
			slol_pkg::S_DONE: begin
				if (out_free) state_nxt = slol_pkg::S_IDLE;
			end
			default: begin
				state_nxt = slol_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			slol_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			slol_pkg::S_DECODE: begin
				if (stat.func == slol_pkg::FUNC_ADD) begin
					cmd.res_full = stat.full;
				end else begin
					cmd.res_absent = stat.absent;
				end
			end
			slol_pkg::S_SCAN: begin
				cmd.scan_step = !stat.scan_hit;
			end
			slol_pkg::S_ADD: begin
				cmd.add_wr = 1'b1;
			end
			slol_pkg::S_WALK: begin
				cmd.read_ent  = stat.steps_zero;
				cmd.walk_step = !stat.steps_zero;
			end
			slol_pkg::S_READ: begin
				cmd.res_ok = 1'b1;
				cmd.unlink = (stat.func != slol_pkg::FUNC_LOOK);
			end
			slol_pkg::S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: rtl/slol_dp.sv
module slol_dp #(
	parameter int DEPTH        = slol_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = slol_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [slol_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [slol_pkg::FUNC_W-1:0]    s_tuser,
	output logic [slol_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [slol_pkg::STATUS_W-1:0]  m_tuser,
	input  slol_pkg::cmd_t                 cmd,
	output slol_pkg::stat_t                stat
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CW > slol_pkg::POS_W) ? CW : slol_pkg::POS_W) + 1;
	localparam int KEEP  = (PAYLOAD_BITS < slol_pkg::DATA_W) ? PAYLOAD_BITS
	                                                         : slol_pkg::DATA_W;
	localparam int PAD_W = slol_pkg::M_TDATA_W - slol_pkg::DATA_W - slol_pkg::COUNT_W;

	// slot store
	logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];
	logic [AW-1:0]           next_mem [DEPTH];
	logic [AW-1:0]           prev_mem [DEPTH];

	// list control state
	logic [DEPTH-1:0] valid_q;
	logic [AW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q;

	// per-operation registers
	slol_pkg::func_t             func_q;
	logic [slol_pkg::POS_W-1:0]  pos_q, steps_q;
	logic [PAYLOAD_BITS-1:0]     data_q;
	logic [AW-1:0]               scan_q, cur_q;
	logic [PAYLOAD_BITS-1:0]     pay_rd_q;
	logic [AW-1:0]               prv_rd_q, nxt_rd_q;
	slol_pkg::status_t           res_status_q;
	logic [slol_pkg::DATA_W-1:0] res_data_q;
	logic [slol_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [slol_pkg::STATUS_W-1:0]  m_tuser_q;

	logic          is_head, is_tail, empty;
	logic          next_we, prev_we;
	logic [AW-1:0] next_wa, next_wd, prev_wa, prev_wd;

	assign empty   = (count_q == '0);
	assign is_head = (pos_q == '0);
	assign is_tail = ((CMP_W'(pos_q) + CMP_W'(1)) == CMP_W'(count_q));

	assign stat.func       = func_q;
	assign stat.full       = (CMP_W'(count_q) == CMP_W'(DEPTH));
	assign stat.absent     = (CMP_W'(pos_q) >= CMP_W'(count_q));
	assign stat.scan_hit   = !valid_q[scan_q];
	assign stat.steps_zero = (steps_q == '0);

	// link write ports: add links after tail, unlink bridges neighbors
	always_comb begin
		next_we = 1'b0;
		next_wa = tail_q;
		next_wd = scan_q;
		prev_we = 1'b0;
		prev_wa = scan_q;
		prev_wd = tail_q;
		if (cmd.add_wr) begin
			next_we = !empty;
			prev_we = 1'b1;
		end else if (cmd.unlink) begin
			next_we = !is_head;
			next_wa = prv_rd_q;
			next_wd = nxt_rd_q;
			prev_we = !is_tail;
			prev_wa = nxt_rd_q;
			prev_wd = prv_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) pay_mem[scan_q] <= data_q;
		if (next_we)    next_mem[next_wa] <= next_wd;
		if (prev_we)    prev_mem[prev_wa] <= prev_wd;
		if (cmd.read_ent) begin
			pay_rd_q <= pay_mem[cur_q];
			prv_rd_q <= prev_mem[cur_q];
			nxt_rd_q <= next_mem[cur_q];
		end
		if (cmd.load) begin
			cur_q <= head_q;
		end else if (cmd.walk_step) begin
			cur_q <= next_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= slol_pkg::func_t'(s_tuser);
			pos_q   <= s_tdata[slol_pkg::POS_W-1:0];
			steps_q <= s_tdata[slol_pkg::POS_W-1:0];
			data_q  <= PAYLOAD_BITS'(s_tdata[slol_pkg::POS_W +: KEEP]);
			scan_q  <= '0;
		end else begin
			if (cmd.scan_step) scan_q <= scan_q + AW'(1);
			if (cmd.walk_step) steps_q <= steps_q - slol_pkg::POS_W'(1);
		end
		if (cmd.res_full) begin
			res_status_q <= slol_pkg::ST_FULL;
			res_data_q   <= '0;
		end else if (cmd.res_absent) begin
			res_status_q <= slol_pkg::ST_ABSENT;
			res_data_q   <= '0;
		end else if (cmd.add_wr) begin
			res_status_q <= slol_pkg::ST_OK;
			res_data_q   <= '0;
		end else if (cmd.res_ok) begin
			res_status_q <= slol_pkg::ST_OK;
			res_data_q   <= (func_q == slol_pkg::FUNC_DELETE) ? '0
			                : slol_pkg::DATA_W'(pay_rd_q[KEEP-1:0]);
		end
		if (cmd.out_load) begin
			m_tdata_q <= {{PAD_W{1'b0}}, slol_pkg::COUNT_W'(count_q), res_data_q};
			m_tuser_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.add_wr) begin
			valid_q[scan_q] <= 1'b1;
			if (empty) head_q <= scan_q;
			tail_q  <= scan_q;
			count_q <= count_q + CW'(1);
		end else if (cmd.unlink) begin
			valid_q[cur_q] <= 1'b0;
			if (is_head) head_q <= nxt_rd_q;
			if (is_tail) tail_q <= prv_rd_q;
			count_q <= count_q - CW'(1);
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count differs from number of valid slots");

	a_add_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> !valid_q[scan_q])
		else $error("add writes into a live slot");

	a_unlink_live_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unlink |-> valid_q[cur_q] && !empty)
		else $error("unlink of a free slot or on an empty list");

	a_scan_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !stat.full && (CMP_W'(scan_q) < CMP_W'(DEPTH - 1)))
		else $error("free-slot scan runs past the store");

endmodule

FILE: rtl/slot_linked_ordered_list_top.sv
// Channel   Dir  tdata                                   tuser
// s_*       in   [3:0] position, [35:4] data_in          [1:0] func
// m_*       out  [31:0] data_out, [36:32] count          [1:0] status
//
// One beat in gives one beat out. Add scans from slot 0 for the lowest free slot
// (scan, one slot per cycle); delete, look and take walk the links up to the position
// (link walk, one memory read per step). A full list or a bad position skips scan and walk.
// Reset clears valid bits, head, tail and count at once; no clearing pass.
// A waiting result sits in the output register while the next beat is taken;
// that beat finishes only when the result has left.
module slot_linked_ordered_list_top #(
	parameter int DEPTH        = slol_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = slol_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// operation beat
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [slol_pkg::S_TDATA_W-1:0] s_tdata,  // position, data_in, pad
	input  logic [slol_pkg::FUNC_W-1:0]    s_tuser,  // func
	// result beat
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [slol_pkg::M_TDATA_W-1:0] m_tdata,  // data_out, count, pad
	output logic [slol_pkg::STATUS_W-1:0]  m_tuser   // status
);

	slol_pkg::cmd_t  cmd;
	slol_pkg::stat_t stat;

	// sequencer: decode, scan, walk, unlink, result handoff
	slol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot store, links, anchors, count and result registers
	slol_dp #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule
